### hw/rtl/pi_ci_pkg.sv
package pi_ci_pkg;

  // field and port widths
  localparam int DataW    = 16;
  localparam int InDataW  = 32;
  localparam int OutDataW = 24;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // bit-serial multiply: one multiplier bit per cycle
  localparam int MulSteps = DataW;
  localparam int StepCntW = $clog2(MulSteps);

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_KP_GAIN    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KI_GAIN    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TARGET     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TOLERANCE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_OUTPUT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_OUTPUT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_REVERSE    = 3'd6;

  // register reset values
  localparam logic [DataW-1:0] TOLERANCE_RST = 16'd2;
  localparam logic [DataW-1:0] MIN_OUT_RST   = 16'hFF00;
  localparam logic [DataW-1:0] MAX_OUT_RST   = 16'h0100;

  // settle counter
  localparam int SettleW = 7;
  localparam logic [SettleW-1:0] SETTLE_LIMIT = 7'd100;
  localparam logic [SettleW-1:0] SETTLE_MAX   = 7'd127;

  // saturation codes
  localparam logic [DataW-1:0] S16_MIN = 16'h8000;
  localparam logic [DataW-1:0] S16_MAX = 16'h7FFF;

endpackage

### hw/rtl/pi_controller_conditional_integration.sv
// a sample runs PREP, MUL1, GUARD, MUL2, INTEG, CLAMP; DRIVE registers the result
// one sample at a time, taken in IDLE; its work is two 16-step bit-serial multiply
//   passes (kp*|err| with ki*|err| side by side, then that product times elapsed_ms)
// a result waiting at the output does not block intake; only the final step stalls
// reset (rst_n low, synchronous) loads register defaults and clears the integral,
//   the settle counter and the output valid
module pi_controller_conditional_integration (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] measured, [31:16] elapsed_ms
  input  logic [pi_ci_pkg::InDataW-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] drive, [16] on_target, [23:17] zero
  output logic [pi_ci_pkg::OutDataW-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [pi_ci_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [pi_ci_pkg::CfgDataW-1:0]    cfg_wdata
);
  import pi_ci_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_GUARD = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_INTEG = 3'd5;
  localparam logic [2:0] ST_CLAMP = 3'd6;
  localparam logic [2:0] ST_DRIVE = 3'd7;

  // configuration registers
  logic [DataW-1:0]        kp_r, ki_r, tol_r;
  logic signed [DataW-1:0] target_r, min_out_r, max_out_r;
  logic                    reverse_r;

  // controller state
  logic signed [DataW-1:0] integral_r;
  logic [SettleW-1:0]      settle_r;

  // sequencer
  logic [2:0]          state_r, state_nxt;
  logic [StepCntW-1:0] step_r;

  // per-sample working registers
  logic signed [DataW-1:0] meas_r;
  logic [DataW-1:0]        elapsed_r;
  logic [DataW-1:0]        mag_r;
  logic                    neg_r;
  logic [DataW-1:0]        mag_sh_r;
  logic [2*DataW-1:0]      kp_sh_r, ki_sh_r;
  logic [2*DataW-1:0]      prod_p_r, prod_q_r;
  logic [3*DataW-1:0]      q_sh_r, prod_r_r;
  logic [DataW-1:0]        el_sh_r;
  logic [34:0]             six_r;
  logic                    guard_r;
  logic signed [49:0]      acc_r;

  // output register
  logic                    out_valid_r;
  logic [DataW-1:0]        drive_r;
  logic                    on_target_r;

  // effective bounds, both zero when crossed
  logic signed [DataW-1:0] lo_c, hi_c;
  always_comb begin
    if (min_out_r > max_out_r) begin
      lo_c = '0;
      hi_c = '0;
    end else begin
      lo_c = min_out_r;
      hi_c = max_out_r;
    end
  end

  // error sign and magnitude from the (optionally negated) sample
  logic signed [DataW-1:0] samp_c;
  logic signed [DataW:0]   err_c, err_n_c;
  always_comb begin
    if (reverse_r) begin
      samp_c = (meas_r == S16_MIN) ? S16_MAX : -meas_r;
    end else begin
      samp_c = meas_r;
    end
    err_c   = {target_r[DataW-1], target_r} - {samp_c[DataW-1], samp_c};
    err_n_c = {samp_c[DataW-1], samp_c} - {target_r[DataW-1], target_r};
  end

  // six times the proportional magnitude
  logic [34:0] six_c;
  assign six_c = {1'b0, prod_p_r, 2'b00} + {2'b00, prod_p_r, 1'b0};

  // integration guard: lo < +-6*kp*|err| < hi
  logic signed [36:0] six_s, hi_e, lo_e;
  logic               guard_c;
  always_comb begin
    six_s = signed'({2'b00, six_r});
    hi_e  = {{21{hi_c[DataW-1]}}, hi_c};
    lo_e  = {{21{lo_c[DataW-1]}}, lo_c};
    if (neg_r) begin
      guard_c = (six_s > -hi_e) && (six_s < -lo_e);
    end else begin
      guard_c = (six_s < hi_e) && (six_s > lo_e);
    end
  end

  // integral update, then clamp
  logic signed [49:0]      int_e50, r_e50, acc_nxt, lo50, hi50;
  logic signed [DataW-1:0] integ_clamp_c;
  always_comb begin
    int_e50 = {{34{integral_r[DataW-1]}}, integral_r};
    r_e50   = signed'({2'b00, prod_r_r});
    if (!guard_r) begin
      acc_nxt = int_e50;
    end else if (neg_r) begin
      acc_nxt = int_e50 - r_e50;
    end else begin
      acc_nxt = int_e50 + r_e50;
    end
    lo50 = {{34{lo_c[DataW-1]}}, lo_c};
    hi50 = {{34{hi_c[DataW-1]}}, hi_c};
    if (acc_r > hi50) begin
      integ_clamp_c = hi_c;
    end else if (acc_r < lo50) begin
      integ_clamp_c = lo_c;
    end else begin
      integ_clamp_c = acc_r[DataW-1:0];
    end
  end

  // drive: proportional plus integral, clamped, optionally negated
  logic signed [33:0]      sum_c, int34, p34, lo34, hi34;
  logic signed [DataW-1:0] drv_c, drv_out_c;
  always_comb begin
    int34 = {{18{integral_r[DataW-1]}}, integral_r};
    p34   = signed'({2'b00, prod_p_r});
    sum_c = neg_r ? (int34 - p34) : (int34 + p34);
    lo34  = {{18{lo_c[DataW-1]}}, lo_c};
    hi34  = {{18{hi_c[DataW-1]}}, hi_c};
    if (sum_c > hi34) begin
      drv_c = hi_c;
    end else if (sum_c < lo34) begin
      drv_c = lo_c;
    end else begin
      drv_c = sum_c[DataW-1:0];
    end
    if (!reverse_r) begin
      drv_out_c = drv_c;
    end else if (drv_c == S16_MIN) begin
      drv_out_c = S16_MAX;
    end else begin
      drv_out_c = -drv_c;
    end
  end

  // settle counter update
  logic [SettleW-1:0] settle_nxt;
  always_comb begin
    if (mag_r <= tol_r) begin
      settle_nxt = (settle_r < SETTLE_MAX) ? settle_r + 1'b1 : settle_r;
    end else begin
      settle_nxt = '0;
    end
  end

  // handshake
  logic in_xfer, out_free;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_MUL1;
      ST_MUL1:  if (step_r == StepCntW'(MulSteps - 1)) state_nxt = ST_GUARD;
      ST_GUARD: state_nxt = ST_MUL2;
      ST_MUL2:  if (step_r == StepCntW'(MulSteps - 1)) state_nxt = ST_INTEG;
      ST_INTEG: state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_DRIVE;
      ST_DRIVE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state, configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      kp_r        <= '0;
      ki_r        <= '0;
      target_r    <= '0;
      tol_r       <= TOLERANCE_RST;
      min_out_r   <= MIN_OUT_RST;
      max_out_r   <= MAX_OUT_RST;
      reverse_r   <= 1'b0;
      integral_r  <= '0;
      settle_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MUL1 || state_r == ST_MUL2) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
      // register writes, setpoint write clears the integral
      if (cfg_we) begin
        case (cfg_index)
          REG_KP_GAIN:    kp_r      <= cfg_wdata;
          REG_KI_GAIN:    ki_r      <= cfg_wdata;
          REG_TARGET: begin
            target_r   <= cfg_wdata;
            integral_r <= '0;
          end
          REG_TOLERANCE:  tol_r     <= cfg_wdata;
          REG_MIN_OUTPUT: min_out_r <= cfg_wdata;
          REG_MAX_OUTPUT: max_out_r <= cfg_wdata;
          REG_REVERSE:    reverse_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == ST_CLAMP) begin
        integral_r <= integ_clamp_c;
        settle_r   <= settle_nxt;
      end
      // output valid
      if (state_r == ST_DRIVE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      meas_r    <= in_tdata[DataW-1:0];
      elapsed_r <= in_tdata[2*DataW-1:DataW];
    end
    case (state_r)
      // error sign, magnitude and multiplier load
      ST_PREP: begin
        neg_r    <= err_c[DataW];
        mag_r    <= err_c[DataW] ? err_n_c[DataW-1:0] : err_c[DataW-1:0];
        mag_sh_r <= err_c[DataW] ? err_n_c[DataW-1:0] : err_c[DataW-1:0];
        kp_sh_r  <= {{DataW{1'b0}}, kp_r};
        ki_sh_r  <= {{DataW{1'b0}}, ki_r};
        prod_p_r <= '0;
        prod_q_r <= '0;
      end
      // kp*|err| and ki*|err|, one multiplier bit per cycle
      ST_MUL1: begin
        if (mag_sh_r[0]) begin
          prod_p_r <= prod_p_r + kp_sh_r;
          prod_q_r <= prod_q_r + ki_sh_r;
        end
        kp_sh_r  <= {kp_sh_r[2*DataW-2:0], 1'b0};
        ki_sh_r  <= {ki_sh_r[2*DataW-2:0], 1'b0};
        mag_sh_r <= {1'b0, mag_sh_r[DataW-1:1]};
      end
      ST_GUARD: begin
        six_r    <= six_c;
        q_sh_r   <= {{DataW{1'b0}}, prod_q_r};
        el_sh_r  <= elapsed_r;
        prod_r_r <= '0;
      end
      // ki*|err| times elapsed_ms, guard evaluated alongside
      ST_MUL2: begin
        if (el_sh_r[0]) begin
          prod_r_r <= prod_r_r + q_sh_r;
        end
        q_sh_r  <= {q_sh_r[3*DataW-2:0], 1'b0};
        el_sh_r <= {1'b0, el_sh_r[DataW-1:1]};
        guard_r <= guard_c;
      end
      ST_INTEG: acc_r <= acc_nxt;
      ST_DRIVE: begin
        if (out_free) begin
          drive_r     <= drv_out_c;
          on_target_r <= (settle_r > SETTLE_LIMIT);
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-DataW-1){1'b0}}, on_target_r, drive_r};

endmodule
